/* rtl/core/homography_point_transform_defines.svh */
// ----------------------------------------------------------------------------
// Homography point transform: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGRAPHY_POINT_TRANSFORM_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HPT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("homography point transform: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("homography point transform: next-cycle check failed");

`endif

/* rtl/core/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// Homography point transform package
// Widths, beat layout, request codes and sequencer states.
// ----------------------------------------------------------------------------
package hpt_pkg;

    // Number format and coefficient table
    localparam int FRAC_BITS  = 16;
    localparam int COEF_COUNT = 16;
    localparam int COEF_IDX_W = $clog2(COEF_COUNT);
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;

    // Row sums of up to four products stay well inside this width.
    localparam int ACC_W = PROD_W + 4;

    // Quotient bits kept by the divider: one above the 32-bit range.
    localparam int Q_W   = DATA_W + 1;
    localparam int BIT_W = $clog2(Q_W);
    localparam int N_W   = ACC_W + FRAC_BITS;
    localparam int CMP_W = ACC_W + Q_W;

    // Beat layout
    localparam int S_FIELDS_W = COEF_IDX_W + 4 * DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 3 * DATA_W;
    localparam int M_TUSER_W  = 2;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index of the mode register
    localparam logic [0:0] CFG_DIM_MODE = 1'b0;

    // Request kinds carried in tuser
    localparam logic REQ_COEF  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    // Mode values
    localparam logic MODE_2D = 1'b0;
    localparam logic MODE_3D = 1'b1;

    // Fixed-point one, used for the homogeneous coordinate
    localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROW,
        ST_DIV_PRE,
        ST_DIV,
        ST_DIV_END,
        ST_DONE
    } hpt_state_t;

endpackage

/* rtl/core/homography_point_transform.sv */
// ----------------------------------------------------------------------------
// Homography point transform
// Maps points through a 3x3 or 4x4 projective matrix in signed Q16.16.
// ----------------------------------------------------------------------------
// A beat with tuser low writes one coefficient into the 16-entry table and is
// taken with no result; the block stays ready. A beat with tuser high
// transforms one point; the block is then busy and drops s_tready until the
// sequencer is done. One shared 32x32 multiplier forms the row sums, one
// product a cycle, and one restoring divider produces the quotients at one
// bit a cycle, in 33 steps after a range check that ends the division early
// when the quotient is out of range. A zero denominator ends the point after
// the denominator row. The finished result sits in an output register, so the
// next beat is taken while it waits on m_tready.
// ----------------------------------------------------------------------------
module homography_point_transform
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, from bit 0: coef_index[3:0], coef_value[31:0], x_in[31:0],
    // y_in[31:0], z_in[31:0], zero padding
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type
    input  logic                  s_tuser,

    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, from bit 0: out_x[31:0], out_y[31:0], out_z[31:0]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser, from bit 0: div_zero, saturated
    output logic [M_TUSER_W-1:0]  m_tuser,

    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Input fields
    logic [COEF_IDX_W-1:0]    in_coef_index;
    logic signed [DATA_W-1:0] in_coef_value;
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;

    assign in_coef_index = s_tdata[COEF_IDX_W-1:0];
    assign in_coef_value = s_tdata[COEF_IDX_W +: DATA_W];
    assign in_x          = s_tdata[COEF_IDX_W + DATA_W +: DATA_W];
    assign in_y          = s_tdata[COEF_IDX_W + 2 * DATA_W +: DATA_W];
    assign in_z          = s_tdata[COEF_IDX_W + 3 * DATA_W +: DATA_W];

    // Control registers
    hpt_state_t       state_reg, state_next;
    logic             dim_mode_reg;
    logic [2:0]       k_reg, k_next;
    logic [1:0]       row_reg, row_next;
    logic             den_phase_reg, den_phase_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Coefficient table, cleared at reset
    logic signed [DATA_W-1:0] coef_reg [COEF_COUNT];

    // Datapath registers
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] y_reg, y_next;
    logic signed [DATA_W-1:0] z_reg, z_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]         dmag_reg, dmag_next;
    logic                     den_neg_reg, den_neg_next;
    logic [N_W-1:0]           num_reg, num_next;
    logic                     neg_reg, neg_next;
    logic [ACC_W-1:0]         rem_reg, rem_next;
    logic [Q_W-1:0]           q_reg, q_next;
    logic                     big_reg, big_next;
    logic [DATA_W-1:0]        res_reg [3];
    logic [DATA_W-1:0]        res_next [3];
    logic                     sat_reg, sat_next;
    logic                     dz_reg, dz_next;
    logic [M_TDATA_W-1:0]     out_data_reg, out_data_next;
    logic [M_TUSER_W-1:0]     out_user_reg, out_user_next;

    // Combinational helpers
    logic                     in_accept;
    logic                     cfg_write;
    logic                     coef_we;
    logic [1:0]               dims;
    logic [2:0]               cols;
    logic [COEF_IDX_W-1:0]    row_base;
    logic [COEF_IDX_W-1:0]    coef_addr;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic [ACC_W-1:0]         acc_mag;
    logic [CMP_W-1:0]         num_ext;
    logic [CMP_W-1:0]         dmag_ext;
    logic [ACC_W:0]           trial;
    logic                     trial_ge;
    logic                     q_big;
    logic [DATA_W-1:0]        div_val;
    logic                     div_sat;

    localparam logic [Q_W-1:0] LIM_BIG = Q_W'(1) << DATA_W;
    localparam logic [Q_W-1:0] LIM_NEG = Q_W'(1) << (DATA_W - 1);
    localparam logic [Q_W-1:0] LIM_POS = LIM_NEG - Q_W'(1);

    // Handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign coef_we   = in_accept && (s_tuser == REQ_COEF);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // Configuration port: one mode register, reads answer at once.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CFG_DIM_MODE);
    assign prdata    = (paddr[2] == CFG_DIM_MODE) ? APB_DATA_W'(dim_mode_reg) : '0;

    // Matrix shape for the current mode
    assign dims = (dim_mode_reg == MODE_3D) ? 2'd3 : 2'd2;
    assign cols = {1'b0, dims} + 3'd1;

    // Table address of the current product: row * cols + k
    always_comb
    begin
        if (dim_mode_reg == MODE_3D)
        begin
            row_base = {row_reg, 2'b00};
        end
        else
        begin
            row_base = {1'b0, row_reg, 1'b0} + {2'b00, row_reg};
        end
        coef_addr = row_base + {2'b00, k_reg[1:0]};
    end

    // Multiplier operands: the point coordinate or the homogeneous one
    assign mul_a = coef_reg[coef_addr];
    always_comb
    begin
        unique case (k_reg[1:0])
            2'd0: mul_b = x_reg;
            2'd1: mul_b = y_reg;
            2'd2: mul_b = (dim_mode_reg == MODE_3D) ? z_reg : FIX_ONE;
            2'd3: mul_b = FIX_ONE;
        endcase
    end

    // Magnitude of the finished row sum
    assign acc_mag = acc_reg[ACC_W-1] ? (ACC_W'(0) - $unsigned(acc_reg)) : $unsigned(acc_reg);

    // Divider step: shift in the next numerator bit and try a subtraction.
    assign num_ext  = CMP_W'(num_reg);
    assign dmag_ext = {dmag_reg, {Q_W{1'b0}}};
    assign trial    = {rem_reg, num_reg[bit_reg]};
    assign trial_ge = (trial >= {1'b0, dmag_reg});

    // Signed, saturated quotient from magnitude and overflow flag
    always_comb
    begin
        q_big = big_reg || (q_reg > LIM_BIG);
        if (neg_reg)
        begin
            if (q_big || (q_reg > LIM_NEG))
            begin
                div_val = {1'b1, {(DATA_W - 1){1'b0}}};
                div_sat = 1'b1;
            end
            else
            begin
                div_val = DATA_W'(0) - q_reg[DATA_W-1:0];
                div_sat = 1'b0;
            end
        end
        else
        begin
            if (q_big || (q_reg > LIM_POS))
            begin
                div_val = {1'b0, {(DATA_W - 1){1'b1}}};
                div_sat = 1'b1;
            end
            else
            begin
                div_val = q_reg[DATA_W-1:0];
                div_sat = 1'b0;
            end
        end
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        den_phase_next = den_phase_reg;
        bit_next       = bit_reg;
        m_tvalid_next  = m_tvalid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        dmag_next      = dmag_reg;
        den_neg_next   = den_neg_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        big_next       = big_reg;
        res_next       = res_reg;
        sat_next       = sat_reg;
        dz_next        = dz_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        // The consumer has taken the waiting result.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Point beats start with the denominator row.
                if (in_accept && (s_tuser == REQ_POINT))
                begin
                    x_next         = in_x;
                    y_next         = in_y;
                    z_next         = in_z;
                    row_next       = dims;
                    den_phase_next = 1'b1;
                    k_next         = 3'd0;
                    res_next       = '{default: '0};
                    sat_next       = 1'b0;
                    dz_next        = 1'b0;
                    state_next     = ST_MAC;
                end
            end

            ST_MAC:
            begin
                // Issue one product a cycle and add the previous one.
                if (k_reg < cols)
                begin
                    prod_next = mul_a * mul_b;
                end
                if (k_reg == 3'd0)
                begin
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (k_reg == cols)
                begin
                    k_next     = 3'd0;
                    state_next = ST_ROW;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end

            ST_ROW:
            begin
                if (den_phase_reg)
                begin
                    // Denominator done: a zero ends the point at once.
                    dmag_next    = acc_mag;
                    den_neg_next = acc_reg[ACC_W-1];
                    if (acc_reg == '0)
                    begin
                        dz_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        den_phase_next = 1'b0;
                        row_next       = 2'd0;
                        state_next     = ST_MAC;
                    end
                end
                else
                begin
                    num_next   = N_W'(acc_mag) << FRAC_BITS;
                    neg_next   = acc_reg[ACC_W-1] ^ den_neg_reg;
                    state_next = ST_DIV_PRE;
                end
            end

            ST_DIV_PRE:
            begin
                // A quotient of 2^33 or more is out of range whatever follows.
                q_next = '0;
                if (num_ext >= dmag_ext)
                begin
                    big_next   = 1'b1;
                    state_next = ST_DIV_END;
                end
                else
                begin
                    big_next   = 1'b0;
                    rem_next   = num_ext[CMP_W-1:Q_W];
                    bit_next   = BIT_W'(Q_W - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // One restoring step a cycle, most significant bit first.
                if (trial_ge)
                begin
                    rem_next = ACC_W'(trial - {1'b0, dmag_reg});
                end
                else
                begin
                    rem_next = trial[ACC_W-1:0];
                end
                q_next = {q_reg[Q_W-2:0], trial_ge};
                if (bit_reg == '0)
                begin
                    state_next = ST_DIV_END;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end

            ST_DIV_END:
            begin
                res_next[row_reg] = div_val;
                sat_next          = sat_reg || div_sat;
                if (row_reg == dims - 2'd1)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = ST_MAC;
                end
            end

            ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    out_data_next = {res_reg[2], res_reg[1], res_reg[0]};
                    out_user_next = {sat_reg, dz_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dim_mode_reg  <= MODE_2D;
            k_reg         <= '0;
            row_reg       <= '0;
            den_phase_reg <= 1'b0;
            bit_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            den_phase_reg <= den_phase_next;
            bit_reg       <= bit_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_write)
            begin
                dim_mode_reg <= pwdata[0];
            end
        end
    end

    // Coefficient table writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_COUNT; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (coef_we)
        begin
            coef_reg[in_coef_index] <= in_coef_value;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        dmag_reg     <= dmag_next;
        den_neg_reg  <= den_neg_next;
        num_reg      <= num_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        big_reg      <= big_next;
        res_reg      <= res_next;
        sat_reg      <= sat_next;
        dz_reg       <= dz_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

/* rtl/core/hpt_checker.sv */
// ----------------------------------------------------------------------------
// Homography point transform port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "homography_point_transform_defines.svh"

module hpt_port_checker
    import hpt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A result that has not been taken stays on offer.
    `HPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // A zero denominator gives zero coordinates and no saturation.
    `HPT_ASSERT_IMPLIES(a_div_zero_clean, m_tvalid && m_tuser[0], (m_tdata == '0) && !m_tuser[1])

    // A point beat makes the block busy in the following cycle.
    `HPT_ASSERT_NEXT(a_point_busy, s_tvalid && s_tready && (s_tuser == REQ_POINT), !s_tready)

    // A coefficient write leaves the block ready for the next beat.
    `HPT_ASSERT_NEXT(a_coef_ready, s_tvalid && s_tready && (s_tuser == REQ_COEF), s_tready)

endmodule

bind homography_point_transform hpt_port_checker u_hpt_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
